FILE: hdl/rsd_pkg.sv
// Package: shared types, constants and the back-reference decoder for the decompressor.
`timescale 1ns / 1ps
package rsd_pkg;

  localparam int unsigned WindowBytes = 131072;
  localparam int unsigned WinAw       = $clog2(WindowBytes);
  localparam int unsigned ResBytes    = 32;
  localparam int unsigned PosW        = 27;
  localparam int unsigned CountW      = 11;
  localparam int unsigned OffW        = 18;

  localparam logic [31:0]     MagicReset   = 32'h0052_4145;
  localparam logic [PosW-1:0] MaxSizeReset = 27'd67108864;
  localparam logic [7:0]      Signature    = 8'hFB;

  // configuration register indexes
  localparam logic CfgMagic   = 1'b0;
  localparam logic CfgMaxSize = 1'b1;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTruncated = 3'd1,
    StBadMagic  = 3'd2,
    StTooLarge  = 3'd3,
    StBadSig    = 3'd4,
    StOffset    = 3'd5,
    StOverflow  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    AftNone = 2'd0,
    AftCopy = 2'd1,
    AftStop = 2'd2
  } aft_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] bytes_0_7;
    logic [63:0] bytes_8_15;
    logic [63:0] bytes_16_23;
    logic [63:0] bytes_24_31;
    logic [5:0]  byte_count;
    logic        last_of_run;
    logic        stream_done;
    logic [2:0]  status;
    logic        short_output;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        lits;
    logic [OffW-1:0]   off;
    logic [CountW-1:0] cnt;
  } ref_t;

  // Decode a short, medium or long back-reference command.
  function automatic ref_t decode_ref(logic [7:0] f, logic [23:0] cb);
    ref_t r;
    if (!f[7]) begin
      r.lits = f[1:0];
      r.off  = {8'd0, f[6:5], cb[7:0]} + 18'd1;
      r.cnt  = {8'd0, f[4:2]} + 11'd3;
    end else if (!f[6]) begin
      r.lits = cb[15:14];
      r.off  = {4'd0, cb[13:8], cb[7:0]} + 18'd1;
      r.cnt  = {5'd0, f[5:0]} + 11'd4;
    end else begin
      r.lits = f[1:0];
      r.off  = {1'b0, f[4], cb[23:16], cb[15:8]} + 18'd1;
      r.cnt  = {1'b0, f[3:2], cb[7:0]} + 11'd5;
    end
    return r;
  endfunction

endpackage

FILE: hdl/rsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hdl/refpack_stream_decompressor.sv
// Top level: streaming RefPack decompressor with history window and result packer.
//
// Usage: compressed bytes enter on the input channel (valid/stall), one byte per
// beat, header first; final_byte marks the last byte available. Decoded bytes
// leave on the output channel in beats of up to 32 bytes, lowest byte first.
// The last beat caused by an input byte has last_of_run set; the beat that ends
// the stream also carries stream_done, status and short_output.
// A byte that yields no result leaves the sequencer idle, so the next byte can be
// taken; one that yields a result is decoded, then loads the output register.
// A back-reference copy moves each copied byte through the single history RAM
// port pair (read, then write back), with one push step per beat.
// Input stall is high whenever the sequencer is not idle.
// Reset returns to the outer header phase; the history RAM is not cleared.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits in its push step. After the stream ends, input beats are
// taken and dropped until reset.
`timescale 1ns / 1ps
module refpack_stream_decompressor
  import rsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SRd   = 4'b0010,
    SWr   = 4'b0100,
    SPush = 4'b1000
  } seq_e;

  typedef enum logic [5:0] {
    PhOuter = 6'b000001,
    PhRphdr = 6'b000010,
    PhCmd   = 6'b000100,
    PhMore  = 6'b001000,
    PhLit   = 6'b010000,
    PhDone  = 6'b100000
  } phase_e;

  seq_e   seq_q, seq_d;
  phase_e phase_q, phase_d;

  logic [31:0]       magic_q, magic_d;
  logic [PosW-1:0]   max_q, max_d;
  logic [3:0]        hidx_q, hidx_d;
  logic [1:0]        flags_q, flags_d;
  logic              mm_q, mm_d;
  logic [31:0]       exp_q, exp_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [7:0]        first_q, first_d;
  logic [23:0]       cb_q, cb_d;
  logic [1:0]        cbl_q, cbl_d;
  logic [7:0]        lits_q, lits_d;
  aft_e              aft_q, aft_d;
  logic [OffW-1:0]   off_q, off_d;
  logic [CountW-1:0] ccnt_q, ccnt_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [ResBytes-1:0][7:0] acc_q, acc_d;
  logic [5:0]        cnt_q, cnt_d;
  logic              endf_q, endf_d;
  status_e           st_q, st_d;
  logic              shrt_q, shrt_d;
  logic              ovalid_q, ovalid_d;
  out_item_t         out_q, out_d;

  logic             ram_we;
  logic [WinAw-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic in_acc;
  logic out_free;

  assign in_stall_o  = (seq_q != SIdle);
  assign in_acc      = in_valid_i && (seq_q == SIdle);
  assign out_free    = !ovalid_q || !out_stall_i;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  assign ram_waddr = pos_q[WinAw-1:0];
  assign ram_raddr = pos_q[WinAw-1:0] - off_q[WinAw-1:0];

  rsd_ram #(
    .Width (8),
    .Depth (WindowBytes)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [7:0]        b;
    logic              emit;
    logic              endf;
    status_e           st;
    logic              shrt;
    logic              go;
    logic              do_lit;
    logic [7:0]        lit_n;
    aft_e              lit_aft;
    logic              do_act;
    aft_e              act;
    logic [OffW-1:0]   c_off;
    logic [CountW-1:0] c_cnt;
    logic [PosW-1:0]   pos_e;
    logic [2:0]        idx;
    logic [3:0]        total;
    ref_t              r;
    logic [23:0]       cb_n;
    logic [7:0]        lits_n;

    seq_d    = seq_q;
    phase_d  = phase_q;
    magic_d  = magic_q;
    max_d    = max_q;
    hidx_d   = hidx_q;
    flags_d  = flags_q;
    mm_d     = mm_q;
    exp_d    = exp_q;
    pos_d    = pos_q;
    first_d  = first_q;
    cb_d     = cb_q;
    cbl_d    = cbl_q;
    lits_d   = lits_q;
    aft_d    = aft_q;
    off_d    = off_q;
    ccnt_d   = ccnt_q;
    rem_d    = rem_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    endf_d   = endf_q;
    st_d     = st_q;
    shrt_d   = shrt_q;
    ovalid_d = ovalid_q && out_stall_i;
    out_d    = out_q;
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;

    b       = in_data_i.in_byte;
    emit    = 1'b0;
    endf    = 1'b0;
    st      = StOk;
    shrt    = 1'b0;
    go      = 1'b0;
    do_lit  = 1'b0;
    lit_n   = '0;
    lit_aft = AftNone;
    do_act  = 1'b0;
    act     = AftNone;
    c_off   = off_q;
    c_cnt   = ccnt_q;
    pos_e   = pos_q;
    idx     = hidx_q[2:0];
    total   = 4'd5;
    r       = decode_ref(first_q, cb_q);
    cb_n    = cb_q;
    lits_n  = lits_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMagic:   magic_d = cfg_wdata_i;
        CfgMaxSize: max_d   = cfg_wdata_i[PosW-1:0];
        default:    ;
      endcase
    end

    unique case (seq_q)
      SIdle: begin
        if (in_acc && phase_q != PhDone) begin
          unique case (phase_q)
            PhOuter: begin
              if (!idx[2]) begin
                if (b != magic_q[{idx[1:0], 3'b000} +: 8]) mm_d = 1'b1;
              end else begin
                exp_d[{idx[1:0], 3'b000} +: 8] = exp_q[{idx[1:0], 3'b000} +: 8] | b;
              end
              hidx_d = {1'b0, idx} + 4'd1;
              if (idx == 3'd7) begin
                hidx_d = '0;
                if (mm_d) begin
                  endf = 1'b1;
                  st   = StBadMagic;
                end else if (exp_d == 32'd0) begin
                  endf = 1'b1;
                end else if (exp_d > {5'd0, max_q}) begin
                  endf = 1'b1;
                  st   = StTooLarge;
                end else begin
                  mm_d    = 1'b0;
                  phase_d = PhRphdr;
                end
              end
            end
            PhRphdr: begin
              if (hidx_q == 4'd0) flags_d = {b[7], b[0]};
              else if (hidx_q == 4'd1 && b != Signature) mm_d = 1'b1;
              hidx_d = hidx_q + 4'd1;
              case (flags_d)
                2'b00:   total = 4'd5;
                2'b01:   total = 4'd8;
                2'b10:   total = 4'd6;
                default: total = 4'd10;
              endcase
              if (hidx_d == 4'd5 && mm_d) begin
                endf = 1'b1;
                st   = StBadSig;
              end else if (hidx_d >= total) begin
                phase_d = PhCmd;
              end
            end
            PhCmd: begin
              first_d = b;
              cb_d    = '0;
              if (!b[7]) begin
                cbl_d   = 2'd1;
                phase_d = PhMore;
              end else if (!b[6]) begin
                cbl_d   = 2'd2;
                phase_d = PhMore;
              end else if (!b[5]) begin
                cbl_d   = 2'd3;
                phase_d = PhMore;
              end else if (b <= Signature) begin
                do_lit  = 1'b1;
                lit_n   = {1'b0, b[4:0], 2'b00} + 8'd4;
                lit_aft = AftNone;
              end else begin
                do_lit  = 1'b1;
                lit_n   = {6'd0, b[1:0]};
                lit_aft = AftStop;
              end
            end
            PhMore: begin
              cb_n  = {cb_q[15:0], b};
              cb_d  = cb_n;
              cbl_d = cbl_q - 2'd1;
              if (cbl_q == 2'd1) begin
                r       = decode_ref(first_q, cb_n);
                off_d   = r.off;
                ccnt_d  = r.cnt;
                c_off   = r.off;
                c_cnt   = r.cnt;
                do_lit  = 1'b1;
                lit_n   = {6'd0, r.lits};
                lit_aft = AftCopy;
              end
            end
            PhLit: begin
              emit   = 1'b1;
              pos_e  = pos_q + 27'd1;
              lits_n = lits_q - 8'd1;
              lits_d = lits_n;
              if (lits_n == 8'd0) begin
                do_act = 1'b1;
                act    = aft_q;
              end
            end
            default: ;
          endcase

          if (do_lit) begin
            if ({5'd0, pos_e} + {24'd0, lit_n} > exp_q) begin
              endf = 1'b1;
              st   = StOverflow;
            end else if (lit_n == 8'd0) begin
              do_act = 1'b1;
              act    = lit_aft;
            end else begin
              lits_d  = lit_n;
              aft_d   = lit_aft;
              phase_d = PhLit;
            end
          end

          if (do_act) begin
            case (act)
              AftCopy: begin
                if (c_off > {1'b0, pos_e[OffW-2:0]} && pos_e < (PosW'(1) << (OffW - 1))) begin
                  endf = 1'b1;
                  st   = StOffset;
                end else if ({5'd0, pos_e} + {21'd0, c_cnt} > exp_q) begin
                  endf = 1'b1;
                  st   = StOverflow;
                end else begin
                  go      = 1'b1;
                  phase_d = PhCmd;
                end
              end
              AftStop: begin
                endf = 1'b1;
                shrt = ({5'd0, pos_e} < exp_q);
              end
              default: phase_d = PhCmd;
            endcase
          end

          if (!endf && in_data_i.final_byte) begin
            endf = 1'b1;
            st   = StTruncated;
          end
          if (endf) phase_d = PhDone;

          if (emit) begin
            ram_we    = 1'b1;
            ram_wdata = b;
          end
          pos_d  = pos_e;
          acc_d  = '0;
          acc_d[0] = emit ? b : 8'd0;
          cnt_d  = {5'd0, emit};
          endf_d = endf;
          st_d   = st;
          shrt_d = shrt;
          if (go) begin
            rem_d = c_cnt;
            seq_d = SRd;
          end else if (emit || endf) begin
            rem_d = '0;
            seq_d = SPush;
          end
        end
      end
      SRd: begin
        seq_d = SWr;
      end
      SWr: begin
        // copy one byte: append, write back to the window, advance
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        acc_d[cnt_q[4:0]] = ram_rdata;
        cnt_d = cnt_q + 6'd1;
        pos_d = pos_q + 27'd1;
        rem_d = rem_q - 11'd1;
        if (cnt_d == 6'(ResBytes) || rem_d == '0) seq_d = SPush;
        else seq_d = SRd;
      end
      SPush: begin
        if (out_free) begin
          ovalid_d           = 1'b1;
          out_d.bytes_0_7    = {acc_q[7], acc_q[6], acc_q[5], acc_q[4],
                                acc_q[3], acc_q[2], acc_q[1], acc_q[0]};
          out_d.bytes_8_15   = {acc_q[15], acc_q[14], acc_q[13], acc_q[12],
                                acc_q[11], acc_q[10], acc_q[9], acc_q[8]};
          out_d.bytes_16_23  = {acc_q[23], acc_q[22], acc_q[21], acc_q[20],
                                acc_q[19], acc_q[18], acc_q[17], acc_q[16]};
          out_d.bytes_24_31  = {acc_q[31], acc_q[30], acc_q[29], acc_q[28],
                                acc_q[27], acc_q[26], acc_q[25], acc_q[24]};
          out_d.byte_count   = cnt_q;
          out_d.last_of_run  = (rem_q == '0);
          out_d.stream_done  = (rem_q == '0) && endf_q;
          out_d.status       = ((rem_q == '0) && endf_q) ? st_q : StOk;
          out_d.short_output = (rem_q == '0) && endf_q && shrt_q;
          acc_d = '0;
          cnt_d = '0;
          seq_d = (rem_q == '0) ? SIdle : SRd;
        end
      end
      default: seq_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= SIdle;
      phase_q  <= PhOuter;
      magic_q  <= MagicReset;
      max_q    <= MaxSizeReset;
      hidx_q   <= '0;
      flags_q  <= '0;
      mm_q     <= 1'b0;
      exp_q    <= '0;
      pos_q    <= '0;
      first_q  <= '0;
      cb_q     <= '0;
      cbl_q    <= '0;
      lits_q   <= '0;
      aft_q    <= AftNone;
      off_q    <= '0;
      ccnt_q   <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      endf_q   <= 1'b0;
      st_q     <= StOk;
      shrt_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      seq_q    <= seq_d;
      phase_q  <= phase_d;
      magic_q  <= magic_d;
      max_q    <= max_d;
      hidx_q   <= hidx_d;
      flags_q  <= flags_d;
      mm_q     <= mm_d;
      exp_q    <= exp_d;
      pos_q    <= pos_d;
      first_q  <= first_d;
      cb_q     <= cb_d;
      cbl_q    <= cbl_d;
      lits_q   <= lits_d;
      aft_q    <= aft_d;
      off_q    <= off_d;
      ccnt_q   <= ccnt_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      endf_q   <= endf_d;
      st_q     <= st_d;
      shrt_q   <= shrt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    out_q <= out_d;
  end

endmodule
